### design/gcalf_pkg.sv
// ---------------------------------------------------------------------------
// Great-circle angle package
// Shared widths, fixed-point constants, register codes and the CORDIC
// arctangent table.
// ---------------------------------------------------------------------------
package gcalf_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int CORDIC_STAGES_DEF = 18;

  localparam int LAT_W   = 24;
  localparam int LON_W   = 25;
  localparam int DEG_W   = 25;
  localparam int ANG_W   = 24;
  localparam int BOOST_W = 17;
  localparam int CFG_W   = 25;
  localparam int IDX_W   = 2;

  // Binary angle, unit vector components (Q2.30) and CORDIC datapath width.
  localparam int TURN_W   = 32;
  localparam int UNIT_W   = 32;
  localparam int CORDIC_W = 34;
  localparam int PROD_W   = 64;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Degrees to turns: |deg| * 2^(32-FRAC_BITS) / 360 = |deg| * 2^(29-FRAC_BITS) / 45.
  localparam int     D2T_SHIFT = 29 - FRAC_BITS;
  localparam int     DIV45_K   = 31;
  localparam int     DIV45_W   = 26;
  localparam longint DIV45_L   = ((longint'(1) <<< DIV45_K) + 44) / 45;
  localparam logic [DIV45_W-1:0] DIV45_M = DIV45_W'(DIV45_L);
  localparam int     QUO_W     = 19;
  localparam int     REM_W     = 6;
  localparam int     FINE_K    = 25;
  localparam int     FINE_W    = 20;
  localparam longint FINE_L    = ((longint'(1) <<< FINE_K) + 44) / 45;
  localparam logic [FINE_W-1:0] FINE_M = FINE_W'(FINE_L);

  // Fade of the light boost between 70 and 90 degrees.
  localparam logic [ANG_W-1:0] FADE_START = ANG_W'(70 <<< FRAC_BITS);
  localparam logic [ANG_W-1:0] FADE_END   = ANG_W'(90 <<< FRAC_BITS);
  localparam int     FADE_W   = 21;
  localparam int     DIV20_K  = 26;
  localparam int     DIV20_W  = 22;
  localparam longint DIV20_L  = ((longint'(1) <<< DIV20_K) + 19) / 20;
  localparam logic [DIV20_W-1:0] DIV20_M = DIV20_W'(DIV20_L);
  localparam logic [BOOST_W-1:0] BOOST_ONE = BOOST_W'(65536);

  localparam logic signed [DEG_W-1:0] HOME_LAT_RST = 25'sd2775034;
  localparam logic signed [DEG_W-1:0] HOME_LON_RST = -25'sd4662367;

  typedef enum logic [IDX_W-1:0] {
    REG_HOME_LAT = 2'd0,
    REG_HOME_LON = 2'd1,
    REG_BOOST_EN = 2'd2
  } cfg_reg_e;

  // atan(2^-i) in turns, 2^32 units per circle.
  function automatic logic [29:0] atan_turn(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      28: r = 30'd3;
      29: r = 30'd1;
      30: r = 30'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/gcalf_if.sv
// ---------------------------------------------------------------------------
// Great-circle angle channel interfaces
// Valid/ready channels for query points and for angle/boost results.
// ---------------------------------------------------------------------------
interface gcalf_pt_if;
  import gcalf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] point_latitude;
  logic signed [LON_W-1:0] point_longitude;

  modport source (output valid, point_latitude, point_longitude, input ready);
  modport sink   (input valid, point_latitude, point_longitude, output ready);
endinterface

interface gcalf_res_if;
  import gcalf_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANG_W-1:0]   angle_degrees;
  logic [BOOST_W-1:0] light_boost;

  modport source (output valid, angle_degrees, light_boost, input ready);
  modport sink   (input valid, angle_degrees, light_boost, output ready);
endinterface

### design/great_circle_angle_light_fade_top.sv
// ---------------------------------------------------------------------------
// Great-circle angle with light fade
// Angular distance of a query point from a configured home point, plus a
// light boost that fades out between 70 and 90 degrees.
// ---------------------------------------------------------------------------
// Usage:
//   Query points enter on pt_i (latitude, longitude in Q.16 degrees); each
//   accepted transaction yields exactly one transaction on res_o carrying the
//   angle (Q.16 degrees, 0 to 180) and the boost (Q1.16).
//   The configuration port writes the home latitude, home longitude and the
//   boost enable; write it only while no transaction is in flight.
//   Throughput is one transaction per cycle while res_o accepts results; the
//   pipeline depth is set by the two CORDIC pipelines and the 32-stage
//   square root.
//   The whole pipeline advances together: when a result sits in the output
//   register and the receiver holds ready low, every stage holds and pt_i
//   ready drops in the same cycle, so nothing is lost or repeated.
//   Reset clears all valid bits and loads the default home point with the
//   boost enabled; no clearing pass is needed.
// ---------------------------------------------------------------------------
module great_circle_angle_light_fade_top #(
  parameter int CORDIC_STAGES = gcalf_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gcalf_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [gcalf_pkg::CFG_W-1:0]     cfg_data_i,
  gcalf_pt_if.sink                        pt_i,
  gcalf_res_if.source                     res_o
);
  import gcalf_pkg::*;

  // Stage count from the input handshake to the output register.
  localparam int LAT = 2 * CORDIC_STAGES + 46;
  localparam int RND = 1 << (31 - FRAC_BITS);
  localparam int ANG_SHIFT = 32 - FRAC_BITS;
  localparam int ANG_PW = 41;

  // Configuration registers.
  logic signed [LAT_W-1:0] home_lat_q;
  logic signed [LON_W-1:0] home_lon_q;
  logic                    boost_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_lat_q <= LAT_W'(HOME_LAT_RST);
      home_lon_q <= HOME_LON_RST;
      boost_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOME_LAT: home_lat_q <= $signed(cfg_data_i[LAT_W-1:0]);
        REG_HOME_LON: home_lon_q <= $signed(cfg_data_i[LON_W-1:0]);
        REG_BOOST_EN: boost_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a held result is refused.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = !res_o.valid || res_o.ready;
  assign pt_i.ready = en;
  assign res_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], pt_i.valid};
    end
  end

  // Degrees to turns for both points; the home point rides along with every
  // query so that no separate precompute is needed.
  logic [TURN_W-1:0] t_hlat, t_hlon, t_plat, t_plon;

  gcalf_deg2turn u_d2t_hlat (.clk_i, .en_i(en), .deg_i(DEG_W'(home_lat_q)), .turn_o(t_hlat));
  gcalf_deg2turn u_d2t_hlon (.clk_i, .en_i(en), .deg_i(home_lon_q),         .turn_o(t_hlon));
  gcalf_deg2turn u_d2t_plat (.clk_i, .en_i(en), .deg_i(DEG_W'(pt_i.point_latitude)),
                             .turn_o(t_plat));
  gcalf_deg2turn u_d2t_plon (.clk_i, .en_i(en), .deg_i(pt_i.point_longitude),
                             .turn_o(t_plon));

  logic signed [UNIT_W-1:0] c_hlat, s_hlat, c_hlon, s_hlon;
  logic signed [UNIT_W-1:0] c_plat, s_plat, c_plon, s_plon;

  gcalf_sincos #(.STAGES(CORDIC_STAGES)) u_sc_hlat (
    .clk_i, .en_i(en), .turn_i(t_hlat), .cos_o(c_hlat), .sin_o(s_hlat));
  gcalf_sincos #(.STAGES(CORDIC_STAGES)) u_sc_hlon (
    .clk_i, .en_i(en), .turn_i(t_hlon), .cos_o(c_hlon), .sin_o(s_hlon));
  gcalf_sincos #(.STAGES(CORDIC_STAGES)) u_sc_plat (
    .clk_i, .en_i(en), .turn_i(t_plat), .cos_o(c_plat), .sin_o(s_plat));
  gcalf_sincos #(.STAGES(CORDIC_STAGES)) u_sc_plon (
    .clk_i, .en_i(en), .turn_i(t_plon), .cos_o(c_plon), .sin_o(s_plon));

  // Unit vectors (cos lon cos lat, sin lon cos lat, sin lat) in Q2.30.
  logic signed [PROD_W-1:0] hx_p, hy_p, px_p, py_p;
  logic signed [UNIT_W-1:0] hx_q, hy_q, hz_q, px_q, py_q, pz_q;

  assign hx_p = PROD_W'(c_hlon) * PROD_W'(c_hlat);
  assign hy_p = PROD_W'(s_hlon) * PROD_W'(c_hlat);
  assign px_p = PROD_W'(c_plon) * PROD_W'(c_plat);
  assign py_p = PROD_W'(s_plon) * PROD_W'(c_plat);

  // Dot product: three products, then the sum, shift and clamp to +-1.
  logic signed [PROD_W-1:0] mx_q, my_q, mz_q;
  logic signed [PROD_W-1:0] dot_sum, dot_sh;
  logic signed [UNIT_W-1:0] dot_q;
  localparam logic signed [PROD_W-1:0] UNIT_ONE = PROD_W'(1) <<< 30;

  assign dot_sum = mx_q + my_q + mz_q;
  assign dot_sh  = dot_sum >>> 30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hx_q <= UNIT_W'(hx_p >>> 30);
      hy_q <= UNIT_W'(hy_p >>> 30);
      hz_q <= s_hlat;
      px_q <= UNIT_W'(px_p >>> 30);
      py_q <= UNIT_W'(py_p >>> 30);
      pz_q <= s_plat;
      mx_q <= PROD_W'(hx_q) * PROD_W'(px_q);
      my_q <= PROD_W'(hy_q) * PROD_W'(py_q);
      mz_q <= PROD_W'(hz_q) * PROD_W'(pz_q);
      if (dot_sh > UNIT_ONE) begin
        dot_q <= UNIT_W'(UNIT_ONE);
      end else if (dot_sh < -UNIT_ONE) begin
        dot_q <= UNIT_W'(-UNIT_ONE);
      end else begin
        dot_q <= UNIT_W'(dot_sh);
      end
    end
  end

  logic signed [CORDIC_W-1:0] ang_turn;

  gcalf_acos #(.STAGES(CORDIC_STAGES)) u_acos (
    .clk_i, .en_i(en), .dot_i(dot_q), .turn_o(ang_turn));

  // Saturate to half a turn and convert to degrees, rounding half up.
  localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(1) <<< 31;
  logic [TURN_W-1:0] t_clamp;
  logic [ANG_PW-1:0] ang_prod;
  logic [ANG_W-1:0]  ang1_q, ang2_q, ang3_q;
  logic              lo2_q, hi2_q;
  logic [FADE_W+DIV20_W-1:0] fade2_q;
  logic [FADE_W-1:0] fade_e;
  logic [BOOST_W-1:0] boost_d;

  always_comb begin
    if (ang_turn[CORDIC_W-1]) begin
      t_clamp = '0;
    end else if (ang_turn > HALF_TURN) begin
      t_clamp = TURN_W'(HALF_TURN);
    end else begin
      t_clamp = TURN_W'(ang_turn);
    end
  end

  assign ang_prod = ANG_PW'(t_clamp) * ANG_PW'(360) + ANG_PW'(RND);
  assign fade_e   = FADE_W'(ang1_q - FADE_START);

  // Fade: 1 - (a - 70 deg) / 20 deg, the divide done by a reciprocal multiply.
  always_comb begin
    if (!boost_en_q || hi2_q) begin
      boost_d = '0;
    end else if (lo2_q) begin
      boost_d = BOOST_ONE;
    end else begin
      boost_d = BOOST_ONE - BOOST_W'(fade2_q >> DIV20_K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang1_q  <= ANG_W'(ang_prod >> ANG_SHIFT);
      ang2_q  <= ang1_q;
      lo2_q   <= ang1_q < FADE_START;
      hi2_q   <= ang1_q >= FADE_END;
      fade2_q <= (FADE_W + DIV20_W)'(fade_e) * (FADE_W + DIV20_W)'(DIV20_M);
      ang3_q  <= ang2_q;
      res_o.light_boost <= boost_d;
    end
  end

  assign res_o.angle_degrees = ang3_q;

endmodule

### design/gcalf_deg2turn.sv
// ---------------------------------------------------------------------------
// Degrees to turns
// Three-stage conversion of a Q.16 degree value into a 32-bit binary angle,
// truncated toward zero, using reciprocal multiplies for the divide by 45.
// ---------------------------------------------------------------------------
module gcalf_deg2turn (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [gcalf_pkg::DEG_W-1:0]  deg_i,
  output logic        [gcalf_pkg::TURN_W-1:0] turn_o
);
  import gcalf_pkg::*;

  localparam int P1_W = DEG_W + DIV45_W;
  localparam int P3_W = REM_W + D2T_SHIFT + FINE_W;

  logic             neg1_q, neg2_q;
  logic [DEG_W-1:0] mag1_q;
  logic [P1_W-1:0]  prod1_q;
  logic [QUO_W-1:0] quo2_q;
  logic [REM_W-1:0] rem2_q;

  logic [DEG_W-1:0]  mag_d;
  logic [QUO_W-1:0]  quo_d;
  logic [DEG_W-1:0]  quo45_d;
  logic [P3_W-1:0]   fine_prod_d;
  logic [TURN_W:0]   q_d;
  logic [TURN_W:0]   turn_d;

  assign mag_d   = deg_i[DEG_W-1] ? DEG_W'(-deg_i) : DEG_W'(deg_i);
  assign quo_d   = QUO_W'(prod1_q >> DIV45_K);
  assign quo45_d = (DEG_W'(quo_d) << 5) + (DEG_W'(quo_d) << 3) + (DEG_W'(quo_d) << 2)
                 + DEG_W'(quo_d);

  // Remainder in turns: floor(r * 2^D2T_SHIFT / 45) for r below 45.
  assign fine_prod_d = (P3_W'(rem2_q) << D2T_SHIFT) * P3_W'(FINE_M);
  assign q_d         = (TURN_W'(quo2_q) << D2T_SHIFT) + (TURN_W + 1)'(fine_prod_d >> FINE_K);
  assign turn_d      = neg2_q ? -q_d : q_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= deg_i[DEG_W-1];
      mag1_q  <= mag_d;
      prod1_q <= P1_W'(mag_d) * P1_W'(DIV45_M);
      neg2_q  <= neg1_q;
      quo2_q  <= quo_d;
      rem2_q  <= REM_W'(mag1_q - quo45_d);
      turn_o  <= turn_d[TURN_W-1:0];
    end
  end

endmodule

### design/gcalf_sincos.sv
// ---------------------------------------------------------------------------
// Pipelined sine/cosine
// Rotation-mode CORDIC, one iteration per register stage, with a quadrant
// fold in front and the sign restore behind.
// ---------------------------------------------------------------------------
module gcalf_sincos #(
  parameter int STAGES = gcalf_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic        [gcalf_pkg::TURN_W-1:0] turn_i,
  output logic signed [gcalf_pkg::UNIT_W-1:0] cos_o,
  output logic signed [gcalf_pkg::UNIT_W-1:0] sin_o
);
  import gcalf_pkg::*;

  logic signed [CORDIC_W-1:0] x_q [STAGES+1];
  logic signed [CORDIC_W-1:0] y_q [STAGES+1];
  logic signed [CORDIC_W-1:0] z_q [STAGES+1];
  logic                       neg_q [STAGES+1];

  logic              fold_d;
  logic [TURN_W-1:0] a_d;

  // Quadrants 1 and 2 are rotated by half a turn and negated at the end.
  assign fold_d = turn_i[TURN_W-1] ^ turn_i[TURN_W-2];
  assign a_d    = {turn_i[TURN_W-1] ^ fold_d, turn_i[TURN_W-2:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= CORDIC_W'($signed(a_d));
      neg_q[0] <= fold_d;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [CORDIC_W-1:0] ATAN = CORDIC_W'(atan_turn(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CORDIC_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= neg_q[STAGES] ? UNIT_W'(-x_q[STAGES]) : UNIT_W'(x_q[STAGES]);
      sin_o <= neg_q[STAGES] ? UNIT_W'(-y_q[STAGES]) : UNIT_W'(y_q[STAGES]);
    end
  end

endmodule

### design/gcalf_acos.sv
// ---------------------------------------------------------------------------
// Pipelined arccosine
// Squares the cosine, takes sqrt(1 - d*d) with a one-bit-per-stage root, and
// finds the angle with a vectoring-mode CORDIC. Result is in turns.
// ---------------------------------------------------------------------------
module gcalf_acos #(
  parameter int STAGES = gcalf_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [gcalf_pkg::UNIT_W-1:0]   dot_i,
  output logic signed [gcalf_pkg::CORDIC_W-1:0] turn_o
);
  import gcalf_pkg::*;

  localparam int SQ_W    = 63;
  localparam int SQ_STEPS = 32;
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << 60;

  logic signed [PROD_W-1:0] dd_q;
  logic signed [UNIT_W-1:0] d1_q;

  logic [SQ_W-1:0]          v_q  [SQ_STEPS+1];
  logic [SQ_W-1:0]          r_q  [SQ_STEPS+1];
  logic signed [UNIT_W-1:0] ds_q [SQ_STEPS+1];

  logic signed [CORDIC_W-1:0] x_q [STAGES+1];
  logic signed [CORDIC_W-1:0] y_q [STAGES+1];
  logic signed [CORDIC_W-1:0] z_q [STAGES+1];

  logic signed [CORDIC_W-1:0] s_d, d_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q    <= PROD_W'(dot_i) * PROD_W'(dot_i);
      d1_q    <= dot_i;
      v_q[0]  <= ONE_SQ - SQ_W'(dd_q);
      r_q[0]  <= '0;
      ds_q[0] <= d1_q;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = r_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[k] >= trial) begin
          v_q[k+1] <= v_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BIT;
        end else begin
          v_q[k+1] <= v_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
        ds_q[k+1] <= ds_q[k];
      end
    end
  end

  assign s_d = CORDIC_W'($signed({1'b0, r_q[SQ_STEPS][UNIT_W-1:0]}));
  assign d_d = CORDIC_W'(ds_q[SQ_STEPS]);

  // A negative cosine starts a quarter turn on, so the vector begins in the
  // right half plane.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (d_d[CORDIC_W-1]) begin
        x_q[0] <= s_d;
        y_q[0] <= -d_d;
        z_q[0] <= CORDIC_W'(1) <<< 30;
      end else begin
        x_q[0] <= d_d;
        y_q[0] <= s_d;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [CORDIC_W-1:0] ATAN = CORDIC_W'(atan_turn(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i][CORDIC_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
      end
    end
  end

  assign turn_o = z_q[STAGES];

endmodule
